// File: design/gap_pkg.sv
// Shared types, constants and command codes for the grid A* path search block.
// Used by the controller, the datapath, the top level and the port checker.
package gap_pkg;

	localparam int MAX_W  = 32;
	localparam int MAX_H  = 32;
	localparam int XW     = $clog2(MAX_W);
	localparam int YW     = $clog2(MAX_H);
	localparam int CW     = XW + YW;
	localparam int NCELLS = MAX_W * MAX_H;
	localparam int GW     = 14;
	localparam int FW     = GW + 1;

	localparam logic [1:0] REQ_TOGGLE = 2'd0;
	localparam logic [1:0] REQ_CLEAR  = 2'd1;
	localparam logic [1:0] REQ_SEARCH = 2'd2;
	localparam logic [1:0] REQ_READ   = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_RANGE  = 2'd1;
	localparam logic [1:0] ST_NOPATH = 2'd2;
	localparam logic [1:0] ST_INDEX  = 2'd3;

	localparam logic [1:0] LS_NONE   = 2'd0;
	localparam logic [1:0] LS_OPEN   = 2'd1;
	localparam logic [1:0] LS_CLOSED = 2'd2;

	localparam logic [2:0] CFG_WIDTH   = 3'd0;
	localparam logic [2:0] CFG_HEIGHT  = 3'd1;
	localparam logic [2:0] CFG_START_X = 3'd2;
	localparam logic [2:0] CFG_START_Y = 3'd3;
	localparam logic [2:0] CFG_GOAL_X  = 3'd4;
	localparam logic [2:0] CFG_GOAL_Y  = 3'd5;

	// Datapath operations issued by the controller.
	localparam logic [4:0] DP_NOP       = 5'd0;
	localparam logic [4:0] DP_LATCH     = 5'd1;
	localparam logic [4:0] DP_LEN_CLR   = 5'd2;
	localparam logic [4:0] DP_CLR_MAP   = 5'd3;
	localparam logic [4:0] DP_CLR_LS    = 5'd4;
	localparam logic [4:0] DP_INIT      = 5'd5;
	localparam logic [4:0] DP_SCAN      = 5'd6;
	localparam logic [4:0] DP_CLOSE     = 5'd7;
	localparam logic [4:0] DP_NB_RD     = 5'd8;
	localparam logic [4:0] DP_NB_NEXT   = 5'd9;
	localparam logic [4:0] DP_NB_UPD    = 5'd10;
	localparam logic [4:0] DP_WALK_INIT = 5'd11;
	localparam logic [4:0] DP_WALK_WR   = 5'd12;
	localparam logic [4:0] DP_WALK_RD   = 5'd13;
	localparam logic [4:0] DP_WALK_UP   = 5'd14;
	localparam logic [4:0] DP_TOG_RD    = 5'd15;
	localparam logic [4:0] DP_TOG_WR    = 5'd16;
	localparam logic [4:0] DP_PT_RD     = 5'd17;
	localparam logic [4:0] DP_PT_UP     = 5'd18;
	localparam logic [4:0] DP_OUT       = 5'd19;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [5:0]  pos_x;
		logic [5:0]  pos_y;
		logic [9:0]  path_index;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        cell_blocked;
		logic [10:0] path_length;
		logic [4:0]  point_x;
		logic [4:0]  point_y;
	} rsp_t;

	typedef struct packed {
		logic [1:0]    ls;
		logic [GW-1:0] g;
		logic [CW-1:0] par;
		logic [CW-1:0] ord;
	} rec_t;

	typedef struct packed {
		logic [4:0] op;
		logic [1:0] st;
	} cmd_t;

	typedef struct packed {
		logic cnt_last;
		logic start_in;
		logic tog_in;
		logic idx_ok;
		logic found;
		logic nb_ok;
		logic nb_last;
		logic goal_open;
		logic open_zero;
		logic walk_done;
		logic out_free;
	} stat_t;

endpackage

// File: design/gap_ctrl.sv
// Controller state machine for the grid A* path search block.
// Depends on gap_pkg; drives gap_dp through cmd_t and reads stat_t.
module gap_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  logic [1:0]    req_type,
	input  gap_pkg::stat_t stat,
	output gap_pkg::cmd_t  cmd
);
	import gap_pkg::*;

	localparam logic [4:0] S_RST_CLR = 5'd0;
	localparam logic [4:0] S_IDLE    = 5'd1;
	localparam logic [4:0] S_TOG     = 5'd2;
	localparam logic [4:0] S_TOGW    = 5'd3;
	localparam logic [4:0] S_CLRM    = 5'd4;
	localparam logic [4:0] S_SRCH    = 5'd5;
	localparam logic [4:0] S_CLRLS   = 5'd6;
	localparam logic [4:0] S_INIT    = 5'd7;
	localparam logic [4:0] S_SCAN    = 5'd8;
	localparam logic [4:0] S_D1      = 5'd9;
	localparam logic [4:0] S_D2      = 5'd10;
	localparam logic [4:0] S_DEC     = 5'd11;
	localparam logic [4:0] S_NB      = 5'd12;
	localparam logic [4:0] S_NBU     = 5'd13;
	localparam logic [4:0] S_CHK     = 5'd14;
	localparam logic [4:0] S_WWR     = 5'd15;
	localparam logic [4:0] S_WRD     = 5'd16;
	localparam logic [4:0] S_WUP     = 5'd17;
	localparam logic [4:0] S_PT      = 5'd18;
	localparam logic [4:0] S_PTU     = 5'd19;
	localparam logic [4:0] S_DONE    = 5'd20;

	logic [4:0] state_q, state_d;
	logic [1:0] st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RST_CLR;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		cmd.op  = DP_NOP;
		cmd.st  = st_q;
		unique case (state_q)
			S_RST_CLR: begin
				cmd.op = DP_CLR_MAP;
				if (stat.cnt_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.op = DP_LATCH;
					unique case (req_type)
						REQ_TOGGLE: state_d = S_TOG;
						REQ_CLEAR:  state_d = S_CLRM;
						REQ_SEARCH: state_d = S_SRCH;
						REQ_READ:   state_d = S_PT;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_TOG: begin
				if (stat.tog_in) begin
					cmd.op  = DP_TOG_RD;
					state_d = S_TOGW;
				end else begin
					st_d    = ST_RANGE;
					state_d = S_DONE;
				end
			end
			S_TOGW: begin
				cmd.op  = DP_TOG_WR;
				st_d    = ST_OK;
				state_d = S_DONE;
			end
			S_CLRM: begin
				cmd.op = DP_CLR_MAP;
				if (stat.cnt_last) begin
					st_d    = ST_OK;
					state_d = S_DONE;
				end
			end
			S_SRCH: begin
				cmd.op = DP_LEN_CLR;
				if (stat.start_in) begin
					state_d = S_CLRLS;
				end else begin
					st_d    = ST_RANGE;
					state_d = S_DONE;
				end
			end
			S_CLRLS: begin
				cmd.op = DP_CLR_LS;
				if (stat.cnt_last) state_d = S_INIT;
			end
			S_INIT: begin
				cmd.op  = DP_INIT;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.op = DP_SCAN;
				if (stat.cnt_last) state_d = S_D1;
			end
			S_D1: state_d = S_D2;
			S_D2: state_d = S_DEC;
			S_DEC: begin
				if (stat.found) begin
					cmd.op  = DP_CLOSE;
					state_d = S_NB;
				end else begin
					st_d    = ST_NOPATH;
					state_d = S_DONE;
				end
			end
			S_NB: begin
				if (stat.nb_ok) begin
					cmd.op  = DP_NB_RD;
					state_d = S_NBU;
				end else begin
					cmd.op = DP_NB_NEXT;
					if (stat.nb_last) state_d = S_CHK;
				end
			end
			S_NBU: begin
				cmd.op  = DP_NB_UPD;
				state_d = stat.nb_last ? S_CHK : S_NB;
			end
			S_CHK: begin
				priority if (stat.goal_open) begin
					cmd.op  = DP_WALK_INIT;
					state_d = S_WWR;
				end else if (stat.open_zero) begin
					st_d    = ST_NOPATH;
					state_d = S_DONE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_WWR: begin
				cmd.op = DP_WALK_WR;
				if (stat.walk_done) begin
					st_d    = ST_OK;
					state_d = S_DONE;
				end else begin
					state_d = S_WRD;
				end
			end
			S_WRD: begin
				cmd.op  = DP_WALK_RD;
				state_d = S_WUP;
			end
			S_WUP: begin
				cmd.op  = DP_WALK_UP;
				state_d = S_WWR;
			end
			S_PT: begin
				if (stat.idx_ok) begin
					cmd.op  = DP_PT_RD;
					state_d = S_PTU;
				end else begin
					st_d    = ST_INDEX;
					state_d = S_DONE;
				end
			end
			S_PTU: begin
				cmd.op  = DP_PT_UP;
				st_d    = ST_OK;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.op  = DP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// File: design/gap_dp.sv
// Datapath of the grid A* path search block: registers, cell memories,
// the open-set scan pipeline and the neighbor update. Depends on gap_pkg.
module gap_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  gap_pkg::cmd_t  cmd,
	output gap_pkg::stat_t stat,
	input  gap_pkg::req_t  req,
	input  logic           cfg_valid,
	input  logic [2:0]     cfg_addr,
	input  logic [5:0]     cfg_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output gap_pkg::rsp_t  rsp
);
	import gap_pkg::*;

	// Configuration registers.
	logic [5:0]    width_q, height_q;
	logic [XW-1:0] sx_q, gx_q;
	logic [YW-1:0] sy_q, gy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 6'(MAX_W);
			height_q <= 6'(MAX_H);
			sx_q     <= '0;
			sy_q     <= '0;
			gx_q     <= '0;
			gy_q     <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				CFG_WIDTH:   width_q  <= cfg_data;
				CFG_HEIGHT:  height_q <= cfg_data;
				CFG_START_X: sx_q     <= cfg_data[XW-1:0];
				CFG_START_Y: sy_q     <= cfg_data[YW-1:0];
				CFG_GOAL_X:  gx_q     <= cfg_data[XW-1:0];
				CFG_GOAL_Y:  gy_q     <= cfg_data[YW-1:0];
				default: ;
			endcase
		end
	end

	logic [5:0] w_eff, h_eff;
	always_comb begin
		priority if (width_q == 6'd0) w_eff = 6'd1;
		else if (width_q > 6'(MAX_W)) w_eff = 6'(MAX_W);
		else w_eff = width_q;
		priority if (height_q == 6'd0) h_eff = 6'd1;
		else if (height_q > 6'(MAX_H)) h_eff = 6'(MAX_H);
		else h_eff = height_q;
	end

	logic [CW-1:0] start_cell, goal_cell;
	logic          goal_in;
	assign start_cell = {sy_q, sx_q};
	assign goal_cell  = {gy_q, gx_q};
	assign goal_in    = ({1'b0, gx_q} < w_eff) && ({1'b0, gy_q} < h_eff);

	// Control and working registers.
	req_t          item_q;
	logic [CW-1:0] cnt_q;
	logic          v_s1, v_s2;
	logic [CW-1:0] idx_s1, idx_s2;
	logic [FW-1:0] f_s2;
	rec_t          rec_s2;
	logic          found_q;
	logic [CW-1:0] bidx_q;
	logic [FW-1:0] bf_q;
	rec_t          brec_q;
	logic [1:0]    ndx_q, ndy_q;
	logic [CW-1:0] order_q;
	logic [CW:0]   open_q;
	logic          goal_open_q;
	logic [CW:0]   len_q;
	logic [CW-1:0] walk_q;
	logic          res_blk_q;
	logic [XW-1:0] res_px_q;
	logic [YW-1:0] res_py_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	// Memory read data.
	rec_t          rec_q;
	logic          obs_q;
	logic [CW-1:0] path_q;

	// Neighbor of the expanded cell.
	logic [5:0]    tx, ty;
	logic [CW-1:0] tcell;
	logic          nb_ok;
	logic [GW-1:0] ng;
	assign tx    = {1'b0, bidx_q[XW-1:0]} + {4'b0, ndx_q} - 6'd1;
	assign ty    = {1'b0, bidx_q[CW-1:XW]} + {4'b0, ndy_q} - 6'd1;
	assign tcell = {ty[YW-1:0], tx[XW-1:0]};
	assign nb_ok = (tx < w_eff) && (ty < h_eff);
	assign ng    = brec_q.g + ((ndx_q != 2'd1 && ndy_q != 2'd1) ? GW'(14) : GW'(10));

	logic nb_new, nb_upd;
	assign nb_new = !obs_q && (rec_q.ls == LS_NONE);
	assign nb_upd = !obs_q && (rec_q.ls == LS_OPEN) && (rec_q.g > ng);

	logic [CW-1:0] item_cell;
	assign item_cell = {item_q.pos_y[YW-1:0], item_q.pos_x[XW-1:0]};

	// Cell record memory.
	rec_t          cell_mem [NCELLS];
	logic          rec_we;
	logic [CW-1:0] rec_wa, rec_ra;
	rec_t          rec_wd;

	always_comb begin
		rec_we = 1'b0;
		rec_wa = cnt_q;
		rec_wd = '0;
		rec_ra = cnt_q;
		unique case (cmd.op)
			DP_CLR_LS: rec_we = 1'b1;
			DP_INIT: begin
				rec_we = 1'b1;
				rec_wa = start_cell;
				rec_wd = '{ls: LS_OPEN, g: '0, par: start_cell, ord: '0};
			end
			DP_CLOSE: begin
				rec_we    = 1'b1;
				rec_wa    = bidx_q;
				rec_wd    = brec_q;
				rec_wd.ls = LS_CLOSED;
			end
			DP_NB_RD: rec_ra = tcell;
			DP_NB_UPD: begin
				rec_we = nb_new || nb_upd;
				rec_wa = tcell;
				rec_wd = '{ls: LS_OPEN, g: ng, par: bidx_q,
					ord: (nb_new ? order_q : rec_q.ord)};
			end
			DP_WALK_RD: rec_ra = walk_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rec_we) cell_mem[rec_wa] <= rec_wd;
		rec_q <= cell_mem[rec_ra];
	end

	// Obstacle memory.
	logic          obs_mem [NCELLS];
	logic          obs_we, obs_wd;
	logic [CW-1:0] obs_wa, obs_ra;

	always_comb begin
		obs_we = 1'b0;
		obs_wa = cnt_q;
		obs_wd = 1'b0;
		obs_ra = tcell;
		unique case (cmd.op)
			DP_CLR_MAP: obs_we = 1'b1;
			DP_TOG_RD:  obs_ra = item_cell;
			DP_TOG_WR: begin
				obs_we = 1'b1;
				obs_wa = item_cell;
				obs_wd = !obs_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (obs_we) obs_mem[obs_wa] <= obs_wd;
		obs_q <= obs_mem[obs_ra];
	end

	// Path memory holds the cells from goal back to start; reads are mirrored.
	logic [CW-1:0] path_mem [NCELLS];
	logic [CW:0]   path_ra_w;
	assign path_ra_w = len_q - (CW+1)'(1) - {1'b0, item_q.path_index};

	always_ff @(posedge clk) begin
		if (cmd.op == DP_WALK_WR) path_mem[len_q[CW-1:0]] <= walk_q;
		path_q <= path_mem[path_ra_w[CW-1:0]];
	end

	// Scan stage: f = g + 10 * Manhattan distance.
	logic [XW-1:0] adx;
	logic [YW-1:0] ady;
	logic [5:0]    msum;
	logic [FW-1:0] hval;
	always_comb begin
		adx  = (gx_q >= idx_s1[XW-1:0]) ? gx_q - idx_s1[XW-1:0] : idx_s1[XW-1:0] - gx_q;
		ady  = (gy_q >= idx_s1[CW-1:XW]) ? gy_q - idx_s1[CW-1:XW]
			: idx_s1[CW-1:XW] - gy_q;
		msum = {1'b0, adx} + {1'b0, ady};
		hval = FW'({msum, 3'b0}) + FW'({msum, 1'b0});
	end

	logic better;
	assign better = v_s2 && (rec_s2.ls == LS_OPEN) && (!found_q || f_s2 < bf_q ||
		(f_s2 == bf_q && rec_s2.ord < brec_q.ord));

	always_ff @(posedge clk) begin
		if (v_s1) begin
			f_s2   <= {1'b0, rec_q.g} + hval;
			rec_s2 <= rec_q;
			idx_s2 <= idx_s1;
		end
		idx_s1 <= cnt_q;
		if (better) begin
			bidx_q <= idx_s2;
			bf_q   <= f_s2;
			brec_q <= rec_s2;
		end
		if (cmd.op == DP_LATCH) item_q <= req;
		if (cmd.op == DP_WALK_INIT) walk_q <= goal_cell;
		if (cmd.op == DP_WALK_UP) walk_q <= rec_q.par;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			found_q     <= 1'b0;
			ndx_q       <= '0;
			ndy_q       <= '0;
			order_q     <= '0;
			open_q      <= '0;
			goal_open_q <= 1'b0;
			len_q       <= '0;
			res_blk_q   <= 1'b0;
			res_px_q    <= '0;
			res_py_q    <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			v_s1 <= (cmd.op == DP_SCAN);
			v_s2 <= v_s1;
			// A new scan starts with no candidate.
			if (cmd.op == DP_INIT || cmd.op == DP_CLOSE) found_q <= 1'b0;
			else if (better) found_q <= 1'b1;
			if (cmd.op == DP_OUT) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
			unique case (cmd.op)
				DP_LATCH: begin
					cnt_q     <= '0;
					res_blk_q <= 1'b0;
					res_px_q  <= '0;
					res_py_q  <= '0;
				end
				DP_LEN_CLR: begin
					cnt_q <= '0;
					len_q <= '0;
				end
				DP_CLR_MAP: begin
					cnt_q <= cnt_q + 1'b1;
					len_q <= '0;
				end
				DP_CLR_LS, DP_SCAN: cnt_q <= cnt_q + 1'b1;
				DP_INIT: begin
					cnt_q       <= '0;
					order_q     <= CW'(1);
					open_q      <= (CW+1)'(1);
					goal_open_q <= 1'b0;
				end
				DP_CLOSE: begin
					cnt_q   <= '0;
					ndx_q   <= '0;
					ndy_q   <= '0;
					open_q  <= open_q - 1'b1;
				end
				DP_NB_NEXT, DP_NB_UPD: begin
					if (cmd.op == DP_NB_UPD && nb_new) begin
						order_q <= order_q + 1'b1;
						open_q  <= open_q + 1'b1;
						if (goal_in && tcell == goal_cell) goal_open_q <= 1'b1;
					end
					if (ndy_q == 2'd2) begin
						ndy_q <= '0;
						ndx_q <= ndx_q + 1'b1;
					end else begin
						ndy_q <= ndy_q + 1'b1;
					end
				end
				DP_WALK_WR: len_q <= len_q + 1'b1;
				DP_TOG_WR: res_blk_q <= !obs_q;
				DP_PT_UP: begin
					res_px_q <= path_q[XW-1:0];
					res_py_q <= path_q[CW-1:XW];
				end
				DP_OUT: begin
					rsp_q <= '{status: cmd.st, cell_blocked: res_blk_q,
						path_length: len_q, point_x: res_px_q, point_y: res_py_q};
				end
				default: ;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		stat.cnt_last  = (cnt_q == {CW{1'b1}});
		stat.start_in  = ({1'b0, sx_q} < w_eff) && ({1'b0, sy_q} < h_eff);
		stat.tog_in    = (item_q.pos_x < w_eff) && (item_q.pos_y < h_eff);
		stat.idx_ok    = ({1'b0, item_q.path_index} < len_q);
		stat.found     = found_q;
		stat.nb_ok     = nb_ok;
		stat.nb_last   = (ndx_q == 2'd2) && (ndy_q == 2'd2);
		stat.goal_open = goal_open_q;
		stat.open_zero = (open_q == '0);
		stat.walk_done = (walk_q == start_cell) || (len_q == (CW+1)'(NCELLS - 1));
		stat.out_free  = !rsp_valid_q || rsp_ready;
	end

endmodule

// File: design/grid_astar_path_search_top.sv
// Top level of the grid A* path search block.
// Depends on gap_pkg, gap_ctrl and gap_dp.
//
// Usage: items arrive on req (valid/ready), one result per item leaves on
// rsp (valid/ready). Registers are written on the cfg channel, which is
// always ready; write them only while the block is idle.
// Item steps, from transfer to result:
//   toggle cell or read path point: one memory read and update, or
//   a direct result when the cell or index is rejected;
//   clear map: one obstacle cell cleared per cycle;
//   search: clear the open/closed marks, then for each expanded cell
//   scan every cell for the least f and update its eight neighbors,
//   then write, read and step back once for each path cell.
//   The worst case is set by the open-set scan of the cell record memory.
// One item is in work at a time; req_ready is high only when idle. A
// finished result waits in the output register while the next item can
// already transfer. If the receiver stalls, the block holds the result
// and waits before it presents the next one.
// After reset the block clears the obstacle map (req_ready low);
// configuration writes are accepted during that time.
module grid_astar_path_search_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  gap_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output gap_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_addr,
	input  logic [5:0]    cfg_data
);
	import gap_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	gap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_type  (req.req_type),
		.stat      (stat),
		.cmd       (cmd)
	);

	gap_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// File: design/gap_checker.sv
// Port-level checker for the grid A* path search block, bound to the top.
// Depends on gap_pkg.
module gap_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input gap_pkg::rsp_t rsp
);
	import gap_pkg::*;

	// One item at a time: ready drops right after an input transfer.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("req_ready stayed high after a transfer");

	// A new result appears only while the block is busy with an item.
	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result appeared while the block was idle");

	// A failed item reports no path point.
	a_point_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.point_x == '0 && rsp.point_y == '0)
		else $error("nonzero point with error status");

	// A stalled result holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

endmodule

bind grid_astar_path_search_top gap_checker u_gap_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
